// File: src/fr_pkg.sv
package fr_pkg;

  localparam logic [1:0] FT_UNFRAG = 2'd0;
  localparam logic [1:0] FT_FIRST  = 2'd1;
  localparam logic [1:0] FT_LATER  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PROTOCOL = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]  proto_id;
    logic [1:0]  frame_type;
    logic [7:0]  frag_id;
    logic [63:0] sender_addr;
    logic [7:0]  frag_offset;
    logic [7:0]  frag_length;
    logic [7:0]  msg_length;
    logic [7:0]  frame_length;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
  } fr_in_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_address;
    logic [7:0] write_data;
    logic       message_done;
    logic [2:0] status;
  } fr_out_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [1:0] frame_type;
    logic [7:0] position;
    logic [7:0] frame_length;
    logic [7:0] frag_length;
    logic [7:0] frag_offset;
    logic [7:0] data_byte;
    logic       done;
  } fr_class_t;

endpackage

// File: src/fr_front.sv
module fr_front import fr_pkg::*; #(
  parameter int unsigned MESSAGE_BYTES = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic      accept_i,
  input  fr_in_t    item_i,
  output fr_class_t class_o
);

  logic [7:0]  dispatch_q, dispatch_d;
  logic [7:0]  held_id_q, held_id_d;
  logic [63:0] held_sender_q, held_sender_d;
  logic [8:0]  remaining_q, remaining_d;
  logic [7:0]  position_q, position_d;
  logic        accepted_q, accepted_d;
  logic        active_q, active_d;

  logic [7:0] pos;
  logic [2:0] judge;
  logic [2:0] status;
  logic [8:0] flen9;
  logic       ok;
  logic       done;

  always_comb begin
    if (item_i.proto_id != dispatch_q) begin
      judge = ST_PROTOCOL;
    end else if ({1'b0, item_i.frame_length} > 9'(MESSAGE_BYTES)) begin
      judge = ST_TOO_BIG;
    end else if (item_i.frame_type == 2'd3) begin
      judge = ST_IGNORED;
    end else begin
      judge = ST_OK;
    end
  end

  always_comb begin
    pos           = item_i.first_byte ? 8'd0 : position_q;
    flen9         = {1'b0, item_i.frag_length};
    held_id_d     = held_id_q;
    held_sender_d = held_sender_q;
    remaining_d   = remaining_q;
    active_d      = active_q;
    accepted_d    = accepted_q;
    status        = ST_OK;
    done          = 1'b0;

    if (item_i.first_byte) begin
      status = judge;
      if (judge == ST_OK) begin
        unique case (item_i.frame_type)
          FT_UNFRAG: begin
            active_d = 1'b0;
          end
          FT_FIRST: begin
            held_id_d     = item_i.frag_id;
            held_sender_d = item_i.sender_addr;
            if (item_i.frag_length <= item_i.msg_length) begin
              remaining_d = {1'b0, item_i.msg_length} - flen9;
              active_d    = 1'b1;
            end else begin
              remaining_d = 9'd0;
              active_d    = 1'b0;
              status      = ST_IGNORED;
            end
          end
          default: begin
            if (active_q && item_i.frag_id == held_id_q
                && item_i.sender_addr == held_sender_q) begin
              if (flen9 <= remaining_q) begin
                remaining_d = remaining_q - flen9;
              end else begin
                remaining_d = 9'd0;
                active_d    = 1'b0;
                status      = ST_IGNORED;
              end
            end else begin
              status = ST_IGNORED;
            end
          end
        endcase
      end
      accepted_d = (status == ST_OK);
    end else if (!accepted_q) begin
      status = (judge == ST_OK) ? ST_IGNORED : judge;
    end

    ok = accepted_d && (status == ST_OK);
    if (ok && item_i.last_byte) begin
      if (item_i.frame_type == FT_UNFRAG) begin
        done = 1'b1;
      end else if (active_d && remaining_d == 9'd0) begin
        done     = 1'b1;
        active_d = 1'b0;
      end
    end

    if (item_i.last_byte) begin
      position_d = 8'd0;
      accepted_d = 1'b0;
    end else begin
      position_d = (pos != 8'd255) ? pos + 8'd1 : 8'd255;
    end

    dispatch_d = cfg_we_i ? cfg_data_i : dispatch_q;
  end

  always_comb begin
    class_o.ok           = ok;
    class_o.status       = status;
    class_o.frame_type   = item_i.frame_type;
    class_o.position     = pos;
    class_o.frame_length = item_i.frame_length;
    class_o.frag_length  = item_i.frag_length;
    class_o.frag_offset  = item_i.frag_offset;
    class_o.data_byte    = item_i.data_byte;
    class_o.done         = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dispatch_q    <= '0;
      held_id_q     <= '0;
      held_sender_q <= '0;
      remaining_q   <= '0;
      position_q    <= '0;
      accepted_q    <= 1'b0;
      active_q      <= 1'b0;
    end else begin
      dispatch_q <= dispatch_d;
      if (accept_i) begin
        held_id_q     <= held_id_d;
        held_sender_q <= held_sender_d;
        remaining_q   <= remaining_d;
        position_q    <= position_d;
        accepted_q    <= accepted_d;
        active_q      <= active_d;
      end
    end
  end

endmodule

// File: src/fr_queue.sv
module fr_queue import fr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fr_class_t class_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output fr_class_t class_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  fr_class_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]        count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign class_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (PtrW+1)'(1);
      2'b01:   count_d = count_q - (PtrW+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= class_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/fr_back.sv
module fr_back import fr_pkg::*; #(
  parameter int unsigned MESSAGE_BYTES = 128,
  parameter int unsigned HEADER_BYTES  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  fr_class_t class_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fr_out_t   out_data_o
);

  logic    valid_q, valid_d;
  fr_out_t data_q, data_d;
  logic    take;
  logic    in_span;
  logic [8:0] target;
  logic [8:0] span_end;
  logic [8:0] pos9;

  assign take  = !valid_q || !out_stall_i;
  assign pop_o = take && q_valid_i;

  always_comb begin
    pos9     = {1'b0, class_i.position};
    span_end = 9'(HEADER_BYTES) + {1'b0, class_i.frag_length};
    in_span  = 1'b0;
    target   = pos9;
    unique case (class_i.frame_type)
      FT_UNFRAG: in_span = class_i.position < class_i.frame_length;
      FT_FIRST:  in_span = pos9 < span_end;
      FT_LATER: begin
        in_span = (pos9 >= 9'(HEADER_BYTES)) && (pos9 < span_end);
        target  = {1'b0, class_i.frag_offset} + pos9;
      end
      default:   in_span = 1'b0;
    endcase

    data_d.write_enable  = 1'b0;
    data_d.write_address = 8'd0;
    data_d.write_data    = class_i.data_byte;
    data_d.message_done  = class_i.done;
    data_d.status        = class_i.status;
    if (class_i.ok && in_span) begin
      if (target < 9'(MESSAGE_BYTES)) begin
        data_d.write_enable  = 1'b1;
        data_d.write_address = target[7:0];
      end else begin
        data_d.status = ST_OVERFLOW;
      end
    end
    valid_d = take ? q_valid_i : valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: src/fragment_reassembler.sv
// channel   direction  handshake                    payload
// in        input      in_valid_i / in_stall_o      in_data_i  (fr_in_t)
// out       output     out_valid_o / out_stall_i    out_data_o (fr_out_t)
// cfg       input      cfg_we_i                     cfg_data_i (dispatch value)
//
// one byte per clock sustained while out_stall_i is low; a byte's result passes the
// queue entry and then the output register before it is on the outputs
// the front classifies and updates frame state in the accept cycle; the back forms
// the write in the output register
// a two-entry queue separates them; in_stall_o rises only when the queue is full
// reset clears the dispatch value, all frame and message state, and the queue
module fragment_reassembler import fr_pkg::*; #(
  parameter int unsigned MESSAGE_BYTES = 128,
  parameter int unsigned HEADER_BYTES  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  fr_in_t     in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output fr_out_t    out_data_o
);

  logic      accept;
  logic      q_full, q_valid, q_pop;
  fr_class_t front_class, back_class;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  fr_front #(
    .MESSAGE_BYTES(MESSAGE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .class_o    (front_class)
  );

  fr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .class_i (front_class),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .class_o (back_class)
  );

  fr_back #(
    .MESSAGE_BYTES(MESSAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .class_i     (back_class),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
